// File: rtl/ahi_pkg.sv
// ----------------------------------------------------------------------------
// ahi_pkg
// Types and constants shared by the attitude history interpolator modules.
// ----------------------------------------------------------------------------
package ahi_pkg;

  localparam int TS_W    = 63;
  localparam int WIN_W   = 36;
  localparam int ANG_W   = 16;
  localparam logic signed [17:0] PI_Q     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
  localparam logic [WIN_W-1:0] WIN_RESET  = 36'd3000000000;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic            func;
    logic [TS_W-1:0] timestamp_ns;
    logic signed [ANG_W-1:0] roll_in;
    logic signed [ANG_W-1:0] pitch_in;
    logic signed [ANG_W-1:0] yaw_in;
  } ahi_in_t;

  typedef struct packed {
    logic            found;
    logic signed [ANG_W-1:0] interp_roll;
    logic signed [ANG_W-1:0] interp_pitch;
    logic signed [ANG_W-1:0] interp_yaw;
    logic [TS_W-1:0] nearest_gap_ns;
  } ahi_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic write;      // write the pushed sample
    logic rd_oldest;  // read time at the oldest slot
    logic rd_scan;    // read time at the scan index
    logic rd_last;    // read time of newest sample
    logic rd_pair;    // read the bracketing pair
    logic drop;       // retire the oldest sample
    logic scan_next;  // advance the scan index
    logic div_start;
    logic div_step;
    logic lerp;
    logic emit;
    logic emit_miss;
  } ahi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic can_drop;   // count above two and oldest older than keep limit
    logic few;        // fewer than two samples
    logic out_range;  // target outside the stored history
    logic scan_hit;   // scanned time is at or after target
    logic scan_end;   // scan index reached the count
    logic div_done;
  } ahi_sts_t;

endpackage

// File: rtl/ahi_ctrl.sv
// ----------------------------------------------------------------------------
// ahi_ctrl
// Sequencer for push, retention drop, search, divide and interpolate steps.
// ----------------------------------------------------------------------------
module ahi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ahi_pkg::ahi_sts_t sts,
  output ahi_pkg::ahi_cmd_t cmd
);
  import ahi_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DEC    = 13'b0000000000010,
    S_DRD    = 13'b0000000000100,
    S_DCHK   = 13'b0000000001000,
    S_QRD    = 13'b0000000010000,
    S_QCHK   = 13'b0000000100000,
    S_SRD    = 13'b0000001000000,
    S_SCHK   = 13'b0000010000000,
    S_PAIR   = 13'b0000100000000,
    S_DIV0   = 13'b0001000000000,
    S_DIV    = 13'b0010000000000,
    S_LERP   = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_query) begin
          cmd.rd_oldest = 1'b1;
          state_nxt = S_QRD;
        end else begin
          cmd.write = 1'b1;
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        cmd.rd_oldest = 1'b1;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (sts.can_drop) begin
          cmd.drop = 1'b1;
          state_nxt = S_DRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_QRD: begin
        if (sts.few) begin
          cmd.emit_miss = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_last = 1'b1;
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (sts.out_range) begin
          cmd.emit_miss = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.scan_end) begin
          cmd.emit_miss = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts.scan_hit) begin
          cmd.rd_pair = 1'b1;
          state_nxt = S_PAIR;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_PAIR: begin
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_LERP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_LERP: begin
        cmd.lerp = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/ahi_dpath.sv
// ----------------------------------------------------------------------------
// ahi_dpath
// Sample ring memories, pointers, serial fraction divider and interpolator.
// ----------------------------------------------------------------------------
module ahi_dpath #(
  parameter int DEPTH     = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ahi_pkg::ahi_in_t             in_word,
  input  logic [ahi_pkg::WIN_W-1:0]    keep_window,
  input  ahi_pkg::ahi_cmd_t            cmd,
  output ahi_pkg::ahi_sts_t            sts,
  output logic                         out_valid,
  output ahi_pkg::ahi_out_t            out_word
);
  import ahi_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int MW = ANG_W + FRAC_BITS + 2;
  localparam int DCW = $clog2(FRAC_BITS + 1);

  logic [TS_W-1:0]    time_mem [DEPTH];
  logic [3*ANG_W-1:0] ang_mem  [DEPTH];

  ahi_in_t         in_r;
  logic [AW-1:0]   oldest_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   scan_r;
  logic [TS_W-1:0] rd_t_r;
  logic [TS_W-1:0] first_t_r;
  logic [TS_W-1:0] ta_r, tb_r;
  logic [3*ANG_W-1:0] aa_r, ab_r;
  logic [TS_W:0]   rem_r;
  logic [TS_W-1:0] den_r;
  logic [FRAC_BITS:0] q_r;
  logic [DCW-1:0]  dcnt_r;
  logic            zero_r;
  logic            ring_full;
  logic signed [ANG_W-1:0] r_r, p_r, y_r;
  logic            out_valid_r;
  ahi_out_t        out_r;
  logic [TS_W-1:0] gap_r;

  logic [AW-1:0] wr_slot, rd_addr, pa_addr, pb_addr;
  logic          rd_en;
  logic [TS_W:0] keep_lim;
  logic          keep_ok;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] i);
    logic [CW-1:0] s;
    s = {1'b0, base} + i;
    if (s >= CW'(DEPTH)) s = s - CW'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] lerp1(
      input logic signed [ANG_W-1:0] a, input logic signed [ANG_W-1:0] b,
      input logic [FRAC_BITS:0] u, input logic wrap);
    logic signed [17:0] d;
    logic signed [MW-1:0] m;
    logic signed [MW-1:0] s;
    logic signed [17:0] v;
    d = 18'(b) - 18'(a);
    if (wrap) begin
      if (d > PI_Q) d = d - TWO_PI_Q;
      else if (d < -PI_Q) d = d + TWO_PI_Q;
    end
    m = MW'(d) * $signed({1'b0, u});
    s = (m + (MW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    v = 18'(a) + 18'(s);
    if (wrap) begin
      if (v > PI_Q) v = v - TWO_PI_Q;
      else if (v < -PI_Q) v = v + TWO_PI_Q;
    end
    return v[ANG_W-1:0];
  endfunction

  assign ring_full = (count_r == CW'(DEPTH));
  assign wr_slot = ring_full ? oldest_r : slot_of(oldest_r, count_r);
  assign keep_ok  = in_r.timestamp_ns >= TS_W'(keep_window);
  assign keep_lim = {1'b0, in_r.timestamp_ns} - (TS_W+1)'(keep_window);
  assign pa_addr  = slot_of(oldest_r, scan_r - CW'(1));
  assign pb_addr  = slot_of(oldest_r, scan_r);
  assign rd_en    = cmd.rd_oldest | cmd.rd_scan | cmd.rd_last;

  always_comb begin
    rd_addr = oldest_r;
    if (cmd.rd_scan) rd_addr = pb_addr;
    else if (cmd.rd_last) rd_addr = slot_of(oldest_r, count_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      time_mem[wr_slot] <= in_r.timestamp_ns;
      ang_mem[wr_slot]  <= {in_r.roll_in, in_r.pitch_in, in_r.yaw_in};
    end
    if (rd_en) rd_t_r <= time_mem[rd_addr];
    if (cmd.rd_pair) begin
      ta_r <= time_mem[pa_addr];
      tb_r <= rd_t_r;
      aa_r <= ang_mem[pa_addr];
      ab_r <= ang_mem[pb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | cmd.emit_miss;
      if (cmd.write) begin
        if (ring_full) oldest_r <= slot_of(oldest_r, CW'(1));
        else count_r <= count_r + CW'(1);
      end
      if (cmd.drop) begin
        oldest_r <= slot_of(oldest_r, CW'(1));
        count_r  <= count_r - CW'(1);
      end
    end
  end

  // The oldest time is read in the decode cycle and held for the range check.
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_word;
    if (cmd.rd_last) first_t_r <= rd_t_r;
    if (cmd.rd_last) scan_r <= CW'(1);
    if (cmd.scan_next) scan_r <= scan_r + CW'(1);
    if (cmd.div_start) begin
      zero_r <= !(tb_r > ta_r && in_r.timestamp_ns >= ta_r);
      rem_r  <= {1'b0, in_r.timestamp_ns - ta_r};
      den_r  <= tb_r - ta_r;
      q_r    <= '0;
      dcnt_r <= '0;
      gap_r  <= ((in_r.timestamp_ns - ta_r) < (tb_r - in_r.timestamp_ns)) ?
                (in_r.timestamp_ns - ta_r) : (tb_r - in_r.timestamp_ns);
    end
    if (cmd.div_step) begin
      if (dcnt_r == '0 && rem_r >= {1'b0, den_r}) begin
        q_r    <= (FRAC_BITS+1)'(1) << FRAC_BITS;
        dcnt_r <= DCW'(FRAC_BITS);
      end else begin
        if ({rem_r[TS_W-1:0], 1'b0} >= {1'b0, den_r}) begin
          rem_r <= {rem_r[TS_W-1:0], 1'b0} - {1'b0, den_r};
          q_r   <= {q_r[FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_r <= {rem_r[TS_W-1:0], 1'b0};
          q_r   <= {q_r[FRAC_BITS-1:0], 1'b0};
        end
        dcnt_r <= dcnt_r + DCW'(1);
      end
    end
    if (cmd.lerp) begin
      r_r <= lerp1(aa_r[3*ANG_W-1:2*ANG_W], ab_r[3*ANG_W-1:2*ANG_W],
                   zero_r ? '0 : q_r, 1'b0);
      p_r <= lerp1(aa_r[2*ANG_W-1:ANG_W], ab_r[2*ANG_W-1:ANG_W],
                   zero_r ? '0 : q_r, 1'b0);
      y_r <= lerp1(aa_r[ANG_W-1:0], ab_r[ANG_W-1:0], zero_r ? '0 : q_r, 1'b1);
    end
    if (cmd.emit) begin
      out_r <= {1'b1, r_r, p_r, y_r, gap_r};
    end else if (cmd.emit_miss) begin
      out_r <= '0;
    end
  end

  always_comb begin
    sts.is_query  = (in_r.func == FUNC_QUERY);
    sts.can_drop  = keep_ok && (count_r > CW'(2)) && ({1'b0, rd_t_r} < keep_lim);
    sts.few       = (count_r < CW'(2));
    sts.out_range = (in_r.timestamp_ns < first_t_r) || (in_r.timestamp_ns > rd_t_r);
    sts.scan_hit  = !(rd_t_r < in_r.timestamp_ns);
    sts.scan_end  = (scan_r >= count_r);
    sts.div_done  = (dcnt_r == DCW'(FRAC_BITS));
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// File: rtl/attitude_history_interpolator.sv
// ----------------------------------------------------------------------------
// attitude_history_interpolator
// Ring of timestamped attitude samples with bracketing search and linear
// interpolation of roll, pitch and yaw at a target time.
// A push keeps busy high while it writes the sample and retires expired samples;
// a query keeps it high while it scans, divides and interpolates, ending early
// on a miss, and its result word is strobed in the first cycle busy is low.
// One word at a time; the next word is accepted in the first idle cycle.
// Reset is synchronous and empties the ring; the receiver cannot stall.
// ----------------------------------------------------------------------------
module attitude_history_interpolator #(
  parameter int DEPTH     = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  ahi_pkg::ahi_in_t          in_word,
  output logic                      out_strobe,
  output ahi_pkg::ahi_out_t         out_word,
  input  logic                      cfg_we,
  input  logic [ahi_pkg::WIN_W-1:0] cfg_keep_window_ns
);
  import ahi_pkg::*;

  logic [WIN_W-1:0] keep_r;
  ahi_cmd_t cmd;
  ahi_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= WIN_RESET;
    end else if (cfg_we) begin
      keep_r <= cfg_keep_window_ns;
    end
  end

  ahi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  ahi_dpath #(.DEPTH(DEPTH), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .keep_window(keep_r),
    .cmd(cmd), .sts(sts), .out_valid(out_strobe), .out_word(out_word)
  );

endmodule
